>>> src/skvt_pkg.sv
// Package for the sorted key/value table: sizes, command and status codes,
// and the word types of the request and response channels. No dependencies.
`default_nettype none
package skvt_pkg;

   localparam int DEPTH = 256;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int ENTRIES_W = 9;
   localparam int ENTRY_W = KEY_W + VAL_W;

   localparam logic [KEY_W-1:0] RESERVED_KEY = '1;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;
   localparam logic [1:0] CMD_PUSH   = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [1:0] STAT_RESERVED  = 2'd3;

   typedef struct packed {
      logic [1:0]       command;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [VAL_W-1:0]     result_value;
      logic [KEY_W-1:0]     assigned_key;
      logic [ENTRIES_W-1:0] entries;
   } rsp_type;

endpackage
`default_nettype wire

>>> src/sorted_key_value_table.sv
// Sorted key/value table: entries kept in key order in one RAM, located by binary search.
// Depends on skvt_pkg and skvt_ram.
// A rejected command (reserved key, or a full table for add or push) goes straight to the done state.
// Find runs a binary search of about log2 of the entry count probes, each a read then a compare.
// Add and delete then move the following entries one by one; push repeats its search once per skipped key.
// One command at a time; reset empties the table at once and clears the push counter.
`default_nettype none
module sorted_key_value_table
   import skvt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SRCH  = 3'd1;
   localparam logic [2:0] ST_SCMP  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_PINC  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0] ctr_ff, ctr_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             up_ff, up_in;
   logic             pv_ff, pv_in;
   logic [IDX_W-1:0] pa_ff, pa_in;
   logic [1:0]       status_ff, status_in;
   logic [VAL_W-1:0] rval_ff, rval_in;
   logic [KEY_W-1:0] akey_ff, akey_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [KEY_W-1:0]   rd_key, ctr_inc;
   logic [VAL_W-1:0]   rd_val;
   logic [CNT_W:0]     mid_sum;
   logic [IDX_W-1:0]   mid;
   logic [CNT_W-1:0]   ptr_dec, mid_inc;
   logic               full, go, goes_right;

   skvt_ram #(
      .WIDTH(ENTRY_W),
      .WORDS(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_key     = rd_data[ENTRY_W-1:VAL_W];
   assign rd_val     = rd_data[VAL_W-1:0];
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = mid_sum[IDX_W:1];
   assign mid_inc    = CNT_W'(mid_ff) + CNT_W'(1);
   assign ptr_dec    = ptr_ff - CNT_W'(1);
   assign ctr_inc    = ctr_ff + KEY_W'(1);
   assign full       = (count_ff >= CNT_W'(DEPTH));
   assign go         = up_ff ? (ptr_ff > lo_ff) : (ptr_ff < count_ff);
   assign goes_right = (cmd_ff == CMD_ADD) ? (rd_key <= key_ff) : (rd_key < key_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      ctr_in       = ctr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      ptr_in       = ptr_ff;
      up_in        = up_ff;
      pv_in        = 1'b0;
      pa_in        = pa_ff;
      status_in    = status_ff;
      rval_in      = rval_ff;
      akey_in      = akey_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.command;
               key_in    = req_data.key;
               val_in    = req_data.value;
               status_in = STAT_OK;
               rval_in   = '0;
               akey_in   = '0;
               lo_in     = '0;
               hi_in     = count_ff;
               priority if (req_data.command == CMD_PUSH) begin
                  if (full) begin
                     status_in = STAT_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = ST_PINC;
                  end
               end else if (req_data.key == RESERVED_KEY) begin
                  status_in = STAT_RESERVED;
                  state_in  = ST_DONE;
               end else if (req_data.command == CMD_ADD && full) begin
                  status_in = STAT_FULL;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_SRCH;
               end
            end
         end
         ST_PINC: begin
            ctr_in   = (ctr_inc == RESERVED_KEY) ? '0 : ctr_inc;
            key_in   = (ctr_inc == RESERVED_KEY) ? '0 : ctr_inc;
            lo_in    = '0;
            hi_in    = count_ff;
            state_in = ST_SRCH;
         end
         ST_SRCH: begin
            if (lo_ff != hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid;
               mid_in   = mid;
               state_in = ST_SCMP;
            end else if (cmd_ff == CMD_ADD) begin
               ptr_in   = count_ff;
               up_in    = 1'b1;
               state_in = ST_SHIFT;
            end else if (lo_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = lo_ff[IDX_W-1:0];
               state_in = ST_CHECK;
            end else if (cmd_ff == CMD_PUSH) begin
               ptr_in   = count_ff;
               up_in    = 1'b1;
               state_in = ST_SHIFT;
            end else begin
               status_in = STAT_NOT_FOUND;
               state_in  = ST_DONE;
            end
         end
         ST_SCMP: begin
            if (goes_right) begin
               lo_in = mid_inc;
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
            state_in = ST_SRCH;
         end
         ST_CHECK: begin
            if (rd_key == key_ff) begin
               unique case (cmd_ff)
                  CMD_PUSH: begin
                     state_in = ST_PINC;
                  end
                  CMD_FIND: begin
                     rval_in  = rd_val;
                     state_in = ST_DONE;
                  end
                  default: begin
                     ptr_in   = lo_ff + CNT_W'(1);
                     up_in    = 1'b0;
                     state_in = ST_SHIFT;
                  end
               endcase
            end else if (cmd_ff == CMD_PUSH) begin
               ptr_in   = count_ff;
               up_in    = 1'b1;
               state_in = ST_SHIFT;
            end else begin
               status_in = STAT_NOT_FOUND;
               state_in  = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (go) begin
               rd_en   = 1'b1;
               rd_addr = up_ff ? ptr_dec[IDX_W-1:0] : ptr_ff[IDX_W-1:0];
               ptr_in  = up_ff ? ptr_dec : ptr_ff + CNT_W'(1);
               pv_in   = 1'b1;
               pa_in   = rd_addr;
            end
            if (pv_ff) begin
               wr_en   = 1'b1;
               wr_addr = up_ff ? pa_ff + IDX_W'(1) : pa_ff - IDX_W'(1);
               wr_data = rd_data;
            end else if (!go) begin
               if (up_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = lo_ff[IDX_W-1:0];
                  wr_data  = {key_ff, val_ff};
                  count_in = count_ff + CNT_W'(1);
                  if (cmd_ff == CMD_PUSH) begin
                     akey_in = key_ff;
                  end
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status       = status_ff;
               rsp_in.result_value = rval_ff;
               rsp_in.assigned_key = akey_ff;
               rsp_in.entries      = ENTRIES_W'(count_ff);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ctr_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ctr_ff       <= ctr_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      ptr_ff    <= ptr_in;
      up_ff     <= up_in;
      pa_ff     <= pa_in;
      status_ff <= status_in;
      rval_ff   <= rval_in;
      akey_ff   <= akey_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The entry count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   // The search window stays ordered while a search runs.
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH || state_ff == ST_SCMP) |-> lo_ff <= hi_ff)
      else $error("search window inverted");

   // The store is written only while entries are being moved or placed.
   a_write_in_shift: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_SHIFT)
      else $error("store written outside shift");

   // The entry count changes only as a command completes.
   a_count_at_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> state_ff == ST_DONE)
      else $error("entry count changed before completion");

   // An accepted word always starts a command sequence.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != ST_IDLE)
      else $error("accepted word did not start a command");

endmodule
`default_nettype wire

>>> src/skvt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; used by the sorted key/value table for its entry store.
`default_nettype none
module skvt_ram #(
   parameter int WIDTH = 64,
   parameter int WORDS = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(WORDS)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(WORDS)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire
